>>> hdl/plnx_pkg.sv
// shared types, widths and reciprocal table for the lattice neighbor index core
package plnx_pkg;

   localparam int SITE_W = 24;
   localparam int DIR_W = 2;
   localparam int EXT_W = 7;
   localparam int COORD_W = 6;
   localparam int RECIP_W = 31;
   localparam int RECIP_SHIFT = 30;
   localparam int MULT_W = SITE_W + RECIP_W;
   localparam int RECIP_NUM = 2 ** RECIP_SHIFT - 1;
   localparam int EXT_RESET = 8;

   typedef enum logic [0:0] {
      REG_TEMPORAL = 1'b0,
      REG_SPATIAL  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SITE_W-1:0] site_index;
      logic [DIR_W-1:0]  direction;
   } req_type;

   typedef struct packed {
      logic [SITE_W-1:0] plus_neighbor;
      logic [SITE_W-1:0] minus_neighbor;
      logic              bad_request;
   } rsp_type;

   typedef struct packed {
      logic [SITE_W-1:0]  site_index;
      logic [DIR_W-1:0]   direction;
      logic [SITE_W-1:0]  quot;
      logic [SITE_W-1:0]  prod;
      logic [COORD_W-1:0] coord;
      logic [EXT_W-1:0]   size;
      logic [SITE_W-1:0]  stride;
   } lane_type;

   // ceil(2^30 / d), exact quotient for any 24 bit dividend and d up to 64
   localparam logic [RECIP_W-1:0] RECIP_TABLE [65] = '{
      31'd0,
      31'(RECIP_NUM / 1 + 1),  31'(RECIP_NUM / 2 + 1),  31'(RECIP_NUM / 3 + 1),
      31'(RECIP_NUM / 4 + 1),  31'(RECIP_NUM / 5 + 1),  31'(RECIP_NUM / 6 + 1),
      31'(RECIP_NUM / 7 + 1),  31'(RECIP_NUM / 8 + 1),  31'(RECIP_NUM / 9 + 1),
      31'(RECIP_NUM / 10 + 1), 31'(RECIP_NUM / 11 + 1), 31'(RECIP_NUM / 12 + 1),
      31'(RECIP_NUM / 13 + 1), 31'(RECIP_NUM / 14 + 1), 31'(RECIP_NUM / 15 + 1),
      31'(RECIP_NUM / 16 + 1), 31'(RECIP_NUM / 17 + 1), 31'(RECIP_NUM / 18 + 1),
      31'(RECIP_NUM / 19 + 1), 31'(RECIP_NUM / 20 + 1), 31'(RECIP_NUM / 21 + 1),
      31'(RECIP_NUM / 22 + 1), 31'(RECIP_NUM / 23 + 1), 31'(RECIP_NUM / 24 + 1),
      31'(RECIP_NUM / 25 + 1), 31'(RECIP_NUM / 26 + 1), 31'(RECIP_NUM / 27 + 1),
      31'(RECIP_NUM / 28 + 1), 31'(RECIP_NUM / 29 + 1), 31'(RECIP_NUM / 30 + 1),
      31'(RECIP_NUM / 31 + 1), 31'(RECIP_NUM / 32 + 1), 31'(RECIP_NUM / 33 + 1),
      31'(RECIP_NUM / 34 + 1), 31'(RECIP_NUM / 35 + 1), 31'(RECIP_NUM / 36 + 1),
      31'(RECIP_NUM / 37 + 1), 31'(RECIP_NUM / 38 + 1), 31'(RECIP_NUM / 39 + 1),
      31'(RECIP_NUM / 40 + 1), 31'(RECIP_NUM / 41 + 1), 31'(RECIP_NUM / 42 + 1),
      31'(RECIP_NUM / 43 + 1), 31'(RECIP_NUM / 44 + 1), 31'(RECIP_NUM / 45 + 1),
      31'(RECIP_NUM / 46 + 1), 31'(RECIP_NUM / 47 + 1), 31'(RECIP_NUM / 48 + 1),
      31'(RECIP_NUM / 49 + 1), 31'(RECIP_NUM / 50 + 1), 31'(RECIP_NUM / 51 + 1),
      31'(RECIP_NUM / 52 + 1), 31'(RECIP_NUM / 53 + 1), 31'(RECIP_NUM / 54 + 1),
      31'(RECIP_NUM / 55 + 1), 31'(RECIP_NUM / 56 + 1), 31'(RECIP_NUM / 57 + 1),
      31'(RECIP_NUM / 58 + 1), 31'(RECIP_NUM / 59 + 1), 31'(RECIP_NUM / 60 + 1),
      31'(RECIP_NUM / 61 + 1), 31'(RECIP_NUM / 62 + 1), 31'(RECIP_NUM / 63 + 1),
      31'(RECIP_NUM / 64 + 1)
   };

endpackage

>>> hdl/plnx_digit.sv
// two stage mixed-radix digit extractor: reciprocal multiply, then remainder
module plnx_digit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [plnx_pkg::DIR_W-1:0]         digit_num,
   input  logic [plnx_pkg::EXT_W-1:0]         divisor,
   input  logic                               in_valid,
   input  plnx_pkg::lane_type                 in_data,
   output logic                               out_valid,
   output plnx_pkg::lane_type                 out_data
);

   logic                                a_valid_ff;
   plnx_pkg::lane_type                  a_data_ff;
   logic [plnx_pkg::MULT_W-1:0]         a_mult_ff;
   logic [plnx_pkg::MULT_W-1:0]         a_mult_in;

   logic                                b_valid_ff;
   plnx_pkg::lane_type                  b_data_ff;
   plnx_pkg::lane_type                  b_data_in;

   logic [plnx_pkg::SITE_W-1:0]         quot_next;
   logic [plnx_pkg::SITE_W-1:0]         quot_back;
   logic [plnx_pkg::SITE_W-1:0]         remainder;

   // stage a: quotient estimate by reciprocal
   assign a_mult_in = plnx_pkg::MULT_W'(in_data.quot) *
                      plnx_pkg::MULT_W'(plnx_pkg::RECIP_TABLE[divisor]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_data_ff <= in_data;
         a_mult_ff <= a_mult_in;
      end
   end

   // stage b: remainder and stride bookkeeping
   assign quot_next = a_mult_ff[plnx_pkg::RECIP_SHIFT +: plnx_pkg::SITE_W];
   assign quot_back = plnx_pkg::SITE_W'(quot_next * plnx_pkg::SITE_W'(divisor));
   assign remainder = a_data_ff.quot - quot_back;

   always_comb begin
      b_data_in = a_data_ff;
      b_data_in.quot = quot_next;
      b_data_in.prod = plnx_pkg::SITE_W'(a_data_ff.prod * plnx_pkg::SITE_W'(divisor));
      if (a_data_ff.direction == digit_num) begin
         b_data_in.coord = remainder[plnx_pkg::COORD_W-1:0];
         b_data_in.size = divisor;
         b_data_in.stride = a_data_ff.prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data = b_data_ff;

endmodule

>>> hdl/plnx_step.sv
// neighbor offset and wrap stage with the response register
module plnx_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic                  in_bad,
   input  plnx_pkg::lane_type    in_data,
   output logic                  out_valid,
   output plnx_pkg::rsp_type     out_data
);

   localparam int PROD_W = plnx_pkg::SITE_W + plnx_pkg::COORD_W;

   logic                          s_valid_ff;
   logic                          s_bad_ff;
   logic [plnx_pkg::SITE_W-1:0]   s_site_ff;
   logic                          s_plus_wrap_ff;
   logic                          s_minus_wrap_ff;
   logic [plnx_pkg::SITE_W-1:0]   s_plus_off_ff;
   logic [plnx_pkg::SITE_W-1:0]   s_minus_off_ff;

   logic                          plus_wrap_in;
   logic                          minus_wrap_in;
   logic [plnx_pkg::SITE_W-1:0]   plus_off_in;
   logic [plnx_pkg::SITE_W-1:0]   minus_off_in;
   logic [plnx_pkg::COORD_W-1:0]  size_less;

   logic                          rsp_valid_ff;
   plnx_pkg::rsp_type             rsp_data_ff;
   plnx_pkg::rsp_type             rsp_data_in;

   assign size_less = plnx_pkg::COORD_W'(in_data.size - 1'b1);
   assign plus_wrap_in = (plnx_pkg::EXT_W'(in_data.coord) + 1'b1) >= in_data.size;
   assign minus_wrap_in = in_data.coord == '0;

   always_comb begin
      if (plus_wrap_in) begin
         plus_off_in = plnx_pkg::SITE_W'(PROD_W'(in_data.coord) * PROD_W'(in_data.stride));
      end else begin
         plus_off_in = in_data.stride;
      end
      if (minus_wrap_in) begin
         minus_off_in = plnx_pkg::SITE_W'(PROD_W'(size_less) * PROD_W'(in_data.stride));
      end else begin
         minus_off_in = in_data.stride;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (advance) begin
         s_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_bad_ff <= in_bad;
         s_site_ff <= in_data.site_index;
         s_plus_wrap_ff <= plus_wrap_in;
         s_minus_wrap_ff <= minus_wrap_in;
         s_plus_off_ff <= plus_off_in;
         s_minus_off_ff <= minus_off_in;
      end
   end

   always_comb begin
      rsp_data_in.bad_request = s_bad_ff;
      if (s_bad_ff) begin
         rsp_data_in.plus_neighbor = '0;
         rsp_data_in.minus_neighbor = '0;
      end else begin
         rsp_data_in.plus_neighbor = s_plus_wrap_ff ? s_site_ff - s_plus_off_ff
                                                    : s_site_ff + s_plus_off_ff;
         rsp_data_in.minus_neighbor = s_minus_wrap_ff ? s_site_ff + s_minus_off_ff
                                                      : s_site_ff - s_minus_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data = rsp_data_ff;

endmodule

>>> hdl/periodic_lattice_neighbor_index_core.sv
// top level of the periodic lattice nearest-neighbor index core
// throughput: one request per cycle when not held; each direction has a two stage divide by its extent
// the whole pipeline holds while a response waits under rsp_stall
// synchronous reset clears all valid bits and sets both extents to 8
module periodic_lattice_neighbor_index_core #(
   parameter int DIMENSIONS = 4,
   parameter int MAX_EXTENT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  plnx_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output plnx_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  plnx_pkg::csr_index_type          csr_index,
   input  logic [plnx_pkg::EXT_W-1:0]       csr_wdata
);

   logic [plnx_pkg::EXT_W-1:0]  temporal_extent_ff;
   logic [plnx_pkg::EXT_W-1:0]  spatial_extent_ff;
   logic [plnx_pkg::EXT_W-1:0]  temporal_use;
   logic [plnx_pkg::EXT_W-1:0]  spatial_use;

   logic                        advance;
   logic                        lane_valid [DIMENSIONS+1];
   plnx_pkg::lane_type          lane_data [DIMENSIONS+1];
   logic                        lane_bad;

   function automatic logic [plnx_pkg::EXT_W-1:0] usable_extent(
      input logic [plnx_pkg::EXT_W-1:0] raw
   );
      logic [plnx_pkg::EXT_W-1:0] v;
      v = raw;
      if (v == '0) begin
         v = plnx_pkg::EXT_W'(1);
      end
      if (v > plnx_pkg::EXT_W'(MAX_EXTENT)) begin
         v = plnx_pkg::EXT_W'(MAX_EXTENT);
      end
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         temporal_extent_ff <= plnx_pkg::EXT_W'(plnx_pkg::EXT_RESET);
         spatial_extent_ff <= plnx_pkg::EXT_W'(plnx_pkg::EXT_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            plnx_pkg::REG_TEMPORAL: begin
               temporal_extent_ff <= csr_wdata;
            end
            plnx_pkg::REG_SPATIAL: begin
               spatial_extent_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign temporal_use = usable_extent(temporal_extent_ff);
   assign spatial_use = usable_extent(spatial_extent_ff);

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      lane_valid[0] = req_valid;
      lane_data[0].site_index = req_data.site_index;
      lane_data[0].direction = req_data.direction;
      lane_data[0].quot = req_data.site_index;
      lane_data[0].prod = plnx_pkg::SITE_W'(1);
      lane_data[0].coord = '0;
      lane_data[0].size = plnx_pkg::EXT_W'(1);
      lane_data[0].stride = plnx_pkg::SITE_W'(1);
   end

   for (genvar k = 0; k < DIMENSIONS; k++) begin : g_digit
      plnx_digit u_digit (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .digit_num (plnx_pkg::DIR_W'(k)),
         .divisor   ((k == 0) ? temporal_use : spatial_use),
         .in_valid  (lane_valid[k]),
         .in_data   (lane_data[k]),
         .out_valid (lane_valid[k+1]),
         .out_data  (lane_data[k+1])
      );
   end

   // leftover quotient means the site lies past the volume; a direction at or above DIMENSIONS is also bad
   assign lane_bad = (lane_data[DIMENSIONS].quot != '0) ||
                     ((plnx_pkg::DIR_W + 1)'(lane_data[DIMENSIONS].direction) >=
                      (plnx_pkg::DIR_W + 1)'(DIMENSIONS));

   plnx_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (lane_valid[DIMENSIONS]),
      .in_bad    (lane_bad),
      .in_data   (lane_data[DIMENSIONS]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_request |->
         rsp_data.plus_neighbor == '0 && rsp_data.minus_neighbor == '0)
      else $error("rejected request with nonzero neighbors");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(u_step.s_valid_ff))
      else $error("response without a request in the last stage");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(lane_valid[DIMENSIONS]))
      else $error("pipeline moved while the response was held");
`endif

endmodule
